### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the seed location merge block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/slm_pkg.sv
// ---------------------------------------------------------------------------
// slm_pkg
// Constants, opcodes and transaction types of the seed location merge block.
// ---------------------------------------------------------------------------
package slm_pkg;

  localparam int KEY_BITS      = 16;
  localparam int LOC_ADDR_BITS = 20;
  localparam int MAX_LOCS      = 64;

  localparam int LOC_PTR_W = LOC_ADDR_BITS + 1;
  localparam int IDX_W     = $clog2(MAX_LOCS);
  localparam int LEN_W     = $clog2(MAX_LOCS + 1);

  localparam logic [31:0] LOC_DEPTH = 32'd1 << LOC_ADDR_BITS;

  localparam logic [1:0] OP_BUCKET_END = 2'd0;
  localparam logic [1:0] OP_LOC_WORD   = 2'd1;
  localparam logic [1:0] OP_MINIMIZER  = 2'd2;
  localparam logic [1:0] OP_END_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [19:0] table_addr;
    logic [31:0] table_data;
    logic [15:0] key;
    logic        strand_bit;
  } slm_req_t;

  typedef struct packed {
    logic [31:0] location;
    logic        strand;
    logic        last;
    logic        empty_res;
    logic        overflow;
  } slm_rsp_t;

endpackage

### src/seed_location_merge_top.sv
// ---------------------------------------------------------------------------
// seed_location_merge_top
// Minimizer seed location merge engine with ping-pong sorted list buffers.
// ---------------------------------------------------------------------------
// Table writes are taken without leaving the idle state. A minimizer
// transaction reads and clamps the bucket bounds, then runs a fetch-then-compare
// step of the shared comparator for each entry placed in the merged list (at
// most MAX_LOCS), over the registered reads of the list buffer and the location
// memory. An end-of-read transaction runs a fetch and a load step for each
// location emitted (or once for an empty read), the load waiting while the
// result side stalls. Input ready is low while a minimizer or end-of-read transaction is in progress.
`include "assert_macros.svh"

module seed_location_merge_top
  import slm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  slm_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output slm_rsp_t rsp
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LO     = 4'd1;
  localparam logic [3:0] S_HI     = 4'd2;
  localparam logic [3:0] S_BND    = 4'd3;
  localparam logic [3:0] S_CLP    = 4'd4;
  localparam logic [3:0] S_MFETCH = 4'd5;
  localparam logic [3:0] S_MCMP   = 4'd6;
  localparam logic [3:0] S_EFETCH = 4'd7;
  localparam logic [3:0] S_ELOAD  = 4'd8;

  logic [3:0]           state;
  logic [KEY_BITS-1:0]  key_r;
  logic                 strand_r;
  logic [31:0]          lo_w;
  logic [LOC_PTR_W-1:0] hi;
  logic [LOC_PTR_W-1:0] j;
  logic [LEN_W-1:0]     i;
  logic [LEN_W-1:0]     n;
  logic [LEN_W-1:0]     length_a;
  logic [LEN_W-1:0]     length_b;
  logic                 sel;
  logic                 overflow_seen;

  logic [31:0] bucket_mem [2**KEY_BITS];
  logic [31:0] loc_mem [2**LOC_ADDR_BITS];
  logic [31:0] buf_a [MAX_LOCS];
  logic [31:0] buf_b [MAX_LOCS];
  logic [31:0] bucket_q;
  logic [31:0] loc_q;
  logic [31:0] a_q;
  logic [31:0] b_q;

  logic                req_fire;
  logic [KEY_BITS-1:0] bucket_raddr;
  logic [LEN_W-1:0]    src_len;
  logic                have_list;
  logic                have_mem;
  logic [31:0]         list_v;
  logic [31:0]         mem_v;
  logic                take_list;
  logic [31:0]         merge_v;
  logic                wr_a;
  logic                wr_b;
  logic                load;
  logic                load_last;
  logic [31:0]         emit_v;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  assign bucket_raddr = (state == S_LO) ? key_r - 1'b1 : key_r;
  assign src_len      = sel ? length_b : length_a;
  assign have_list    = (i < src_len);
  assign have_mem     = (j < hi);
  assign list_v       = sel ? b_q : a_q;
  assign mem_v        = loc_q ^ {31'd0, strand_r};
  assign take_list    = have_list && (!have_mem || (list_v <= mem_v));
  assign merge_v      = take_list ? list_v : mem_v;
  assign wr_a         = (state == S_MCMP) && sel;
  assign wr_b         = (state == S_MCMP) && !sel;
  assign load         = (state == S_ELOAD) && (!rsp_valid || rsp_ready);
  assign load_last    = (src_len == '0) || (i + 1'b1 == src_len);
  assign emit_v       = sel ? b_q : a_q;

  always_ff @(posedge clk) begin
    if (req_fire && (req.opcode == OP_BUCKET_END)) begin
      bucket_mem[KEY_BITS'(req.table_addr)] <= req.table_data;
    end
    bucket_q <= bucket_mem[bucket_raddr];
  end

  always_ff @(posedge clk) begin
    if (req_fire && (req.opcode == OP_LOC_WORD)) begin
      loc_mem[LOC_ADDR_BITS'(req.table_addr)] <= req.table_data;
    end
    loc_q <= loc_mem[j[LOC_ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      buf_a[n[IDX_W-1:0]] <= merge_v;
    end
    a_q <= buf_a[i[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      buf_b[n[IDX_W-1:0]] <= merge_v;
    end
    b_q <= buf_b[i[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      length_a      <= '0;
      length_b      <= '0;
      sel           <= 1'b0;
      overflow_seen <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire && (req.opcode == OP_MINIMIZER)) begin
            state <= S_LO;
          end else if (req_fire && (req.opcode == OP_END_READ)) begin
            state <= S_EFETCH;
          end
        end
        S_LO:  state <= S_HI;
        S_HI:  state <= S_BND;
        S_BND: state <= S_CLP;
        S_CLP: state <= S_MFETCH;
        S_MFETCH: begin
          if ((n == LEN_W'(MAX_LOCS)) || (!have_list && !have_mem)) begin
            if (have_list || have_mem) begin
              overflow_seen <= 1'b1;
            end
            if (sel) begin
              length_a <= n;
            end else begin
              length_b <= n;
            end
            sel   <= ~sel;
            state <= S_IDLE;
          end else begin
            state <= S_MCMP;
          end
        end
        S_MCMP:   state <= S_MFETCH;
        S_EFETCH: state <= S_ELOAD;
        S_ELOAD: begin
          if (load) begin
            if (load_last) begin
              length_a      <= '0;
              length_b      <= '0;
              sel           <= 1'b0;
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end else begin
              state <= S_EFETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      key_r    <= KEY_BITS'(req.key);
      strand_r <= req.strand_bit;
      i        <= '0;
      n        <= '0;
    end
    if (state == S_HI) begin
      lo_w <= (key_r == '0) ? 32'd0 : bucket_q;
    end
    if (state == S_BND) begin
      hi <= (bucket_q > LOC_DEPTH) ? LOC_PTR_W'(LOC_DEPTH) : LOC_PTR_W'(bucket_q);
    end
    if (state == S_CLP) begin
      j <= (lo_w > 32'(hi)) ? hi : LOC_PTR_W'(lo_w);
    end
    if (state == S_MCMP) begin
      n <= n + 1'b1;
      if (take_list) begin
        i <= i + 1'b1;
      end else begin
        j <= j + 1'b1;
      end
    end
    if (load && !load_last) begin
      i <= i + 1'b1;
    end
    if (load) begin
      if (src_len == '0) begin
        rsp.location  <= 32'd0;
        rsp.strand    <= 1'b0;
        rsp.last      <= 1'b1;
        rsp.empty_res <= 1'b1;
      end else begin
        rsp.location  <= {emit_v[31:1], 1'b0};
        rsp.strand    <= emit_v[0];
        rsp.last      <= load_last;
        rsp.empty_res <= 1'b0;
      end
      rsp.overflow <= overflow_seen;
    end
  end

  `SLM_ASSERT_NOW(a_merge_in_range, clk, rst, state == S_MCMP, n < LEN_W'(MAX_LOCS), "merge write beyond capacity")
  `SLM_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, (length_a <= LEN_W'(MAX_LOCS)) && (length_b <= LEN_W'(MAX_LOCS)), "list length beyond capacity")
  `SLM_ASSERT_NOW(a_bucket_ptr, clk, rst, state == S_MFETCH, j <= hi, "bucket pointer past bucket end")
  `SLM_ASSERT_NEXT(a_read_cleared, clk, rst, load && load_last, (state == S_IDLE) && (length_a == '0) && (length_b == '0) && !sel && !overflow_seen, "list not cleared after end of read")

endmodule

### bench/tb_seed_location_merge_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_seed_location_merge_top
// Self-checking bench for the seed location merge engine. Tables are loaded
// through write transactions, all transactions are sent with random gaps
// outside the back-to-back test, and every emitted location is checked against
// a merge predictor that keeps its own ping-pong hit lists and table copies.
// ---------------------------------------------------------------------------
module tb_seed_location_merge_top;
  import slm_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_LIMIT   = 50000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam longint      RUN_LIMIT_NS  = 12_000_000;

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  slm_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  slm_rsp_t rsp;

  bit calm;
  bit hold_pending;

  // predictor state
  logic [31:0] bucket_end_mem [int unsigned];
  logic [31:0] loc_word_mem [int unsigned];
  logic [31:0] hit_list [2][MAX_LOCS];
  int unsigned hit_count [2];
  bit          hit_side;
  bit          hit_dropped;
  slm_rsp_t    expected_hits [$];
  logic [15:0] seeded_keys [$];

  int unsigned sent_count;
  int unsigned reads_done;
  int unsigned empty_reads;
  int unsigned overflow_reads;
  int unsigned hits_checked;
  int unsigned mismatch_count;
  int unsigned fail_count;

  seed_location_merge_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void predict_hits(input slm_req_t t);
    slm_rsp_t    hit;
    int unsigned lo, hi, i, j, n, src_len;
    logic [31:0] word;
    bit          src, dst, have_list, have_mem;
    case (t.opcode)
      OP_BUCKET_END: begin
        bucket_end_mem[{16'd0, t.table_addr[KEY_BITS-1:0]}] = t.table_data;
      end
      OP_LOC_WORD: begin
        loc_word_mem[{12'd0, t.table_addr[LOC_ADDR_BITS-1:0]}] = t.table_data;
      end
      OP_MINIMIZER: begin
        lo = (t.key == 16'd0) ? 0 : bucket_end_mem[32'(t.key) - 1];
        hi = bucket_end_mem[32'(t.key)];
        if (hi > LOC_DEPTH) hi = LOC_DEPTH;
        if (lo > hi) lo = hi;
        src = hit_side;
        dst = !hit_side;
        src_len = hit_count[src];
        i = 0;
        j = lo;
        n = 0;
        while (n < MAX_LOCS) begin
          have_list = i < src_len;
          have_mem = j < hi;
          if (!have_list && !have_mem) break;
          word = 32'd0;
          if (have_mem) word = loc_word_mem[j] ^ {31'd0, t.strand_bit};
          if (have_list && (!have_mem || hit_list[src][i] <= word)) begin
            hit_list[dst][n] = hit_list[src][i];
            i++;
          end else begin
            hit_list[dst][n] = word;
            j++;
          end
          n++;
        end
        if (i < src_len || j < hi) hit_dropped = 1'b1;
        hit_count[dst] = n;
        hit_side = dst;
      end
      default: begin
        reads_done++;
        if (hit_count[hit_side] == 0) begin
          empty_reads++;
          hit.location = 32'd0;
          hit.strand = 1'b0;
          hit.last = 1'b1;
          hit.empty_res = 1'b1;
          hit.overflow = hit_dropped;
          expected_hits.push_back(hit);
        end else begin
          for (n = 0; n < hit_count[hit_side]; n++) begin
            word = hit_list[hit_side][n];
            hit.location = {word[31:1], 1'b0};
            hit.strand = word[0];
            hit.last = (n + 1 == hit_count[hit_side]);
            hit.empty_res = 1'b0;
            hit.overflow = hit_dropped;
            expected_hits.push_back(hit);
          end
        end
        if (hit_dropped) overflow_reads++;
        hit_count[0] = 0;
        hit_count[1] = 0;
        hit_side = 1'b0;
        hit_dropped = 1'b0;
      end
    endcase
  endfunction

  function automatic slm_req_t minimizer_item(input logic [15:0] k, input logic s);
    slm_req_t t;
    t.opcode = OP_MINIMIZER;
    t.table_addr = 20'($urandom);
    t.table_data = $urandom;
    t.key = k;
    t.strand_bit = s;
    return t;
  endfunction

  function automatic slm_req_t end_read_item();
    slm_req_t t;
    t = slm_req_t'({$urandom, $urandom, $urandom});
    t.opcode = OP_END_READ;
    return t;
  endfunction

  task automatic send_item(input slm_req_t item);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 16) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_hits(item);
    sent_count++;
  endtask

  task automatic table_write(input logic [1:0] op, input logic [19:0] addr,
                             input logic [31:0] data);
    slm_req_t t;
    t.opcode = op;
    t.table_addr = addr;
    t.table_data = data;
    t.key = 16'($urandom);
    t.strand_bit = 1'($urandom);
    send_item(t);
  endtask

  // pick an unused key, give it a bucket and fill every entry a merge can read
  task automatic seed_new_bucket(output logic [15:0] k);
    int unsigned     lo, hi_raw, hi, top, a, roll;
    logic [31:0]     w;
    longint unsigned nxt;
    bit              shuffled;
    do
      k = 16'($urandom);
    while (bucket_end_mem.exists(32'(k)) ||
           (k != 16'd0 && bucket_end_mem.exists(32'(k) - 1)));
    roll = $urandom_range(99);
    lo = (k == 16'd0) ? 0 : $urandom_range(LOC_DEPTH - 1);
    if (roll < 65) begin
      hi_raw = lo + $urandom_range(1, 8);
    end else if (roll < 73) begin
      hi_raw = lo;
    end else if (roll < 80) begin
      hi_raw = (lo >= 40) ? lo - $urandom_range(1, 40) : 0;
    end else if (roll < 90) begin
      hi_raw = lo + $urandom_range(9, 40);
    end else if (roll < 95) begin
      hi_raw = lo + $urandom_range(60, 100);
    end else begin
      if (k != 16'd0) lo = LOC_DEPTH - $urandom_range(1, 12);
      hi_raw = $urandom_range(32'hFFFF_FFFF, LOC_DEPTH);
    end
    if (k != 16'd0) table_write(OP_BUCKET_END, {4'($urandom), k - 16'd1}, lo);
    table_write(OP_BUCKET_END, {4'($urandom), k}, hi_raw);
    hi = (hi_raw > LOC_DEPTH) ? LOC_DEPTH : hi_raw;
    top = (hi > lo + MAX_LOCS) ? lo + MAX_LOCS : hi;
    shuffled = $urandom_range(99) < 10;
    w = $urandom >> $urandom_range(0, 12);
    for (a = lo; a < top; a++) begin
      table_write(OP_LOC_WORD, a[19:0], w);
      if (shuffled) begin
        w = $urandom;
      end else begin
        nxt = longint'(w) + $urandom_range(0, 1 << $urandom_range(0, 24));
        w = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
      end
    end
    seeded_keys.push_back(k);
  endtask

  task automatic run_reads(input int unsigned item_goal);
    int unsigned stop, n_min, roll;
    logic [15:0] k;
    stop = sent_count + item_goal;
    while (sent_count < stop) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_item(end_read_item());
      end else if (roll < 8) begin
        table_write(OP_LOC_WORD, 20'($urandom), $urandom);
      end else if (roll < 12) begin
        k = 16'($urandom);
        if (bucket_end_mem.exists(32'(k)))
          table_write(OP_BUCKET_END, {4'($urandom), k}, bucket_end_mem[32'(k)]);
        else
          table_write(OP_BUCKET_END, {4'($urandom), k}, $urandom);
      end
      n_min = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 5);
      repeat (n_min) begin
        if ($urandom_range(99) < 25)
          seed_new_bucket(k);
        else
          k = seeded_keys[$urandom_range(seeded_keys.size() - 1)];
        send_item(minimizer_item(k, 1'($urandom)));
      end
      send_item(end_read_item());
    end
  endtask

  task automatic test_empty_read_after_reset();
    send_item(end_read_item());
  endtask

  // key 1 starts where it ends, key 3 starts past its end
  task automatic test_small_buckets();
    table_write(OP_BUCKET_END, 20'hF_0000, 32'd3);
    table_write(OP_BUCKET_END, 20'h3_0001, 32'd3);
    table_write(OP_BUCKET_END, 20'h0_0002, 32'd6);
    table_write(OP_BUCKET_END, 20'hA_0003, 32'd2);
    table_write(OP_LOC_WORD, 20'd0, 32'h0000_0000);
    table_write(OP_LOC_WORD, 20'd1, 32'h0000_0010);
    table_write(OP_LOC_WORD, 20'd2, 32'hFFFF_FFFF);
    table_write(OP_LOC_WORD, 20'd3, 32'h0000_0010);
    table_write(OP_LOC_WORD, 20'd4, 32'h8000_0001);
    table_write(OP_LOC_WORD, 20'd5, 32'hFFFF_FFFE);
    send_item(minimizer_item(16'd0, 1'b0));
    send_item(minimizer_item(16'd2, 1'b1));
    send_item(minimizer_item(16'd1, 1'b1));
    send_item(minimizer_item(16'd3, 1'b0));
    send_item(end_read_item());
    send_item(minimizer_item(16'd1, 1'b0));
    send_item(end_read_item());
    seeded_keys = {16'd0, 16'd1, 16'd2, 16'd3};
  endtask

  // bucket end far beyond the location table
  task automatic test_bucket_end_clamp();
    table_write(OP_BUCKET_END, 20'hF_FFFE, LOC_DEPTH - 3);
    table_write(OP_BUCKET_END, 20'hF_FFFF, 32'hFFFF_FFFF);
    table_write(OP_LOC_WORD, 20'hF_FFFD, 32'h0000_0001);
    table_write(OP_LOC_WORD, 20'hF_FFFE, 32'h7FFF_FFFF);
    table_write(OP_LOC_WORD, 20'hF_FFFF, 32'hFFFF_FFFF);
    send_item(minimizer_item(16'd2, 1'b0));
    send_item(minimizer_item(16'hFFFF, 1'b1));
    send_item(end_read_item());
    send_item(end_read_item());
    seeded_keys.push_back(16'hFFFF);
  endtask

  // fill past capacity, then hold the result side while input keeps coming
  task automatic test_capacity_under_backpressure();
    int unsigned a;
    logic [31:0] w;
    table_write(OP_BUCKET_END, 20'd199, 32'h0000_1000);
    table_write(OP_BUCKET_END, 20'd200, 32'h0000_1046);
    w = $urandom_range(0, 32'h00FF_FFFF);
    for (a = 32'h1000; a < 32'h1040; a++) begin
      table_write(OP_LOC_WORD, a[19:0], w);
      w = w + $urandom_range(0, 32'h00FF_FFFF);
    end
    send_item(minimizer_item(16'd0, 1'b0));
    send_item(minimizer_item(16'd200, 1'b0));
    send_item(minimizer_item(16'd2, 1'b1));
    hold_pending = 1'b1;
    send_item(end_read_item());
    send_item(minimizer_item(16'd0, 1'b1));
    send_item(end_read_item());
    seeded_keys.push_back(16'd200);
  endtask

  task automatic test_back_to_back_reads();
    calm = 1'b1;
    run_reads(25);
    calm = 1'b0;
  endtask

  task automatic test_random_reads();
    run_reads(35);
  endtask

  task automatic finish_run();
    int unsigned waited;
    req_valid <= 1'b0;
    waited = 0;
    while (expected_hits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_hits.size() != 0) begin
      $display("Timed out with %0d locations still outstanding", expected_hits.size());
      $display("seed_location_merge_top verification failed");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      $display("Sent %0d transactions over %0d reads (%0d empty, %0d truncated at capacity).",
               sent_count, reads_done, empty_reads, overflow_reads);
      $display("Checked %0d location transactions, %0d failures.", hits_checked, fail_count);
      if (fail_count == 0)
        $display("seed_location_merge_top verification clean");
      else
        $display("seed_location_merge_top verification failed");
    end
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_read_after_reset();
    test_small_buckets();
    test_bucket_end_clamp();
    test_capacity_under_backpressure();
    test_back_to_back_reads();
    test_random_reads();
    finish_run();
  end

  initial begin : rsp_side
    int unsigned hold_left;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    slm_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_hits.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected location transaction: loc=%h s=%b last=%b empty=%b ovf=%b",
                   rsp.location, rsp.strand, rsp.last, rsp.empty_res, rsp.overflow);
      end else begin
        want = expected_hits.pop_front();
        hits_checked++;
        if ((!want.empty_res && rsp.location != want.location) ||
            rsp.strand != want.strand || rsp.last != want.last ||
            rsp.empty_res != want.empty_res || rsp.overflow != want.overflow) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: exp loc=%h s=%b last=%b empty=%b ovf=%b",
                     want.location, want.strand, want.last, want.empty_res, want.overflow);
            $display("          got loc=%h s=%b last=%b empty=%b ovf=%b",
                     rsp.location, rsp.strand, rsp.last, rsp.empty_res, rsp.overflow);
          end
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached before the stimulus completed");
    $display("seed_location_merge_top verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/slm_pkg.sv
src/seed_location_merge_top.sv
bench/tb_seed_location_merge_top.sv
